// ===== design/u8u16_pkg.sv =====
// shared types and constants for the utf-8 to utf-16 transcoder
// no dependencies; used by the front, queue, back and top level files
package u8u16_pkg;

    localparam logic [15:0] REPL_UNIT    = 16'hFFFD;
    localparam logic [20:0] MIN_LEN2     = 21'h00080;
    localparam logic [20:0] MIN_LEN3     = 21'h00800;
    localparam logic [20:0] MIN_LEN4     = 21'h10000;
    localparam logic [20:0] MAX_POINT    = 21'h10FFFF;
    localparam logic [20:0] SURR_FIRST   = 21'h0D800;
    localparam logic [20:0] SURR_LAST    = 21'h0DFFF;
    localparam logic [20:0] BMP_LAST     = 21'h0FFFF;
    localparam logic [15:0] HI_SURR_BASE = 16'hD800;
    localparam logic [15:0] LO_SURR_BASE = 16'hDC00;
    localparam logic [9:0]  SURR_MASK    = 10'h3FF;

    localparam logic [2:0] LEN_TWO   = 3'd2;
    localparam logic [2:0] LEN_THREE = 3'd3;
    localparam logic [2:0] LEN_FOUR  = 3'd4;

    localparam logic [1:0] TAIL_NONE   = 2'd0;
    localparam logic [1:0] TAIL_SINGLE = 2'd1;
    localparam logic [1:0] TAIL_PAIR   = 2'd2;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // last slot index and the count that means full
    localparam logic [QUEUE_AW-1:0] QUEUE_LAST_SLOT = QUEUE_AW'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_CW-1:0] QUEUE_FULL_CNT  = QUEUE_CW'(QUEUE_DEPTH);

    // one classified byte: some replacement units, then up to two real units
    typedef struct packed {
        logic [1:0]  rep_cnt;
        logic [1:0]  tail_n;
        logic [15:0] tail_hi;
        logic [15:0] tail_lo;
        logic        last;
    } t_job;

endpackage

// ===== design/utf8_to_utf16_transcoder.sv =====
// top level of the utf-8 to utf-16 transcoder
// depends on u8u16_pkg, u8u16_front, u8u16_queue and u8u16_back
//
//   channel | signals                                        | direction
//   --------+------------------------------------------------+----------
//   in      | i_in_valid, o_in_stall, i_byte_in, i_last_byte | byte in
//   out     | o_out_valid, i_out_stall, o_code_unit,         | unit out
//           | o_run_end, o_text_end                          |
//
// one byte is taken per cycle while the job queue has room; a job's code units
// go out through the output register once it reaches the head of the two-entry
// queue, one unit per cycle unless i_out_stall holds them, so a surrogate pair
// or a broken sequence holds the output for each extra unit
// o_in_stall rises only when the job queue is full, from its count register
// synchronous active-low reset clears the pending sequence, queue and output
module utf8_to_utf16_transcoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_byte_in,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_code_unit,
    output logic        o_run_end,
    output logic        o_text_end
);

    logic            accept;
    logic            push;
    logic            pop;
    logic            q_full;
    logic            q_nonempty;
    u8u16_pkg::t_job front_job;
    u8u16_pkg::t_job head_job;

    // the front end runs when a byte is offered and the queue has room; bytes that
    // give no unit (a lead or a middle continuation) only update the held state
    assign accept     = i_in_valid && !q_full;
    assign o_in_stall = q_full;

    u8u16_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte_in   (i_byte_in),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_job       (front_job)
    );

    // decouples classification from unit expansion
    u8u16_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_job      (front_job),
        .i_pop      (pop),
        .o_full     (q_full),
        .o_nonempty (q_nonempty),
        .o_head     (head_job)
    );

    // replacement units first, then the decoded unit or surrogate pair
    u8u16_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_nonempty),
        .i_job       (head_job),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_code_unit (o_code_unit),
        .o_run_end   (o_run_end),
        .o_text_end  (o_text_end)
    );

endmodule

// ===== design/u8u16_front.sv =====
// front end: holds the partly assembled code point and classifies each byte
// into a job for the back end; depends on u8u16_pkg
module u8u16_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_byte_in,
    input  logic            i_last_byte,
    output logic            o_push,
    output u8u16_pkg::t_job o_job
);

    logic [20:0] r_partial, n_partial;
    logic [1:0]  r_held, n_held;
    logic [2:0]  r_expect, n_expect;

    logic        is_cont;
    logic        held_nz;
    logic [20:0] acc;
    logic [2:0]  held_inc;
    logic        bad;
    logic [19:0] supp;
    logic [1:0]  rep_cnt;
    logic [1:0]  tail_n;
    logic [15:0] tail_hi;
    logic [15:0] tail_lo;

    assign is_cont  = (i_byte_in[7:6] == 2'b10);
    assign held_nz  = (r_held != 2'd0);
    assign acc      = {r_partial[14:0], i_byte_in[5:0]};
    assign held_inc = {1'b0, r_held} + 3'd1;
    assign supp     = 20'(acc - u8u16_pkg::MIN_LEN4);

    always_comb begin
        case (r_expect)
            u8u16_pkg::LEN_TWO:   bad = (acc < u8u16_pkg::MIN_LEN2);
            u8u16_pkg::LEN_THREE: bad = (acc < u8u16_pkg::MIN_LEN3) ||
                                        ((acc >= u8u16_pkg::SURR_FIRST) &&
                                         (acc <= u8u16_pkg::SURR_LAST));
            default:              bad = (acc < u8u16_pkg::MIN_LEN4) ||
                                        (acc > u8u16_pkg::MAX_POINT);
        endcase
    end

    always_comb begin
        n_partial = r_partial;
        n_held    = r_held;
        n_expect  = r_expect;
        rep_cnt   = 2'd0;
        tail_n    = u8u16_pkg::TAIL_NONE;
        tail_hi   = u8u16_pkg::REPL_UNIT;
        tail_lo   = u8u16_pkg::REPL_UNIT;

        if (held_nz && is_cont) begin
            if (held_inc == r_expect) begin
                // sequence complete
                n_partial = '0;
                n_held    = 2'd0;
                n_expect  = 3'd0;
                if (bad || acc <= u8u16_pkg::BMP_LAST) begin
                    tail_n  = u8u16_pkg::TAIL_SINGLE;
                    tail_hi = bad ? u8u16_pkg::REPL_UNIT : acc[15:0];
                end else begin
                    tail_n  = u8u16_pkg::TAIL_PAIR;
                    tail_hi = u8u16_pkg::HI_SURR_BASE + {6'd0, supp[19:10]};
                    tail_lo = u8u16_pkg::LO_SURR_BASE
                              + {6'd0, supp[9:0] & u8u16_pkg::SURR_MASK};
                end
            end else if (i_last_byte) begin
                // text ends mid-sequence
                rep_cnt   = held_inc[1:0];
                n_partial = '0;
                n_held    = 2'd0;
                n_expect  = 3'd0;
            end else begin
                n_partial = acc;
                n_held    = held_inc[1:0];
            end
        end else begin
            // flush whatever is held, then decode as a fresh byte
            rep_cnt   = r_held;
            n_partial = '0;
            n_held    = 2'd0;
            n_expect  = 3'd0;
            if (!i_byte_in[7]) begin
                tail_n  = u8u16_pkg::TAIL_SINGLE;
                tail_hi = {8'd0, i_byte_in};
            end else if (i_byte_in[7:5] == 3'b110 || i_byte_in[7:4] == 4'b1110 ||
                         i_byte_in[7:3] == 5'b11110) begin
                if (i_last_byte) begin
                    tail_n = u8u16_pkg::TAIL_SINGLE;
                end else begin
                    n_held = 2'd1;
                    if (i_byte_in[7:5] == 3'b110) begin
                        n_expect  = u8u16_pkg::LEN_TWO;
                        n_partial = {16'd0, i_byte_in[4:0]};
                    end else if (i_byte_in[7:4] == 4'b1110) begin
                        n_expect  = u8u16_pkg::LEN_THREE;
                        n_partial = {17'd0, i_byte_in[3:0]};
                    end else begin
                        n_expect  = u8u16_pkg::LEN_FOUR;
                        n_partial = {18'd0, i_byte_in[2:0]};
                    end
                end
            end else begin
                // lone continuation or invalid lead
                tail_n = u8u16_pkg::TAIL_SINGLE;
            end
        end
    end

    assign o_push        = i_accept && ((rep_cnt != 2'd0) || (tail_n != u8u16_pkg::TAIL_NONE));
    assign o_job.rep_cnt = rep_cnt;
    assign o_job.tail_n  = tail_n;
    assign o_job.tail_hi = tail_hi;
    assign o_job.tail_lo = tail_lo;
    assign o_job.last    = i_last_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_partial <= '0;
            r_held    <= 2'd0;
            r_expect  <= 3'd0;
        end else if (i_accept) begin
            r_partial <= n_partial;
            r_held    <= n_held;
            r_expect  <= n_expect;
        end
    end

endmodule

// ===== design/u8u16_queue.sv =====
// short job queue between front and back end
// depends on u8u16_pkg for the job type and depth
module u8u16_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  u8u16_pkg::t_job i_job,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output u8u16_pkg::t_job o_head
);

    u8u16_pkg::t_job                r_slot [u8u16_pkg::QUEUE_DEPTH];
    logic [u8u16_pkg::QUEUE_AW-1:0] r_wr, r_rd;
    logic [u8u16_pkg::QUEUE_CW-1:0] r_cnt;
    logic                           do_pop;

    assign o_full     = (r_cnt == u8u16_pkg::QUEUE_FULL_CNT);
    assign o_nonempty = (r_cnt != '0);
    assign o_head     = r_slot[r_rd];
    assign do_pop     = i_pop && o_nonempty;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == u8u16_pkg::QUEUE_LAST_SLOT) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == u8u16_pkg::QUEUE_LAST_SLOT) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && do_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// ===== design/u8u16_back.sv =====
// back end: expands the head job into code units, one per cycle unless the
// output stalls, into the output register; depends on u8u16_pkg
module u8u16_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_job_valid,
    input  u8u16_pkg::t_job i_job,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output logic [15:0]     o_code_unit,
    output logic            o_run_end,
    output logic            o_text_end
);

    logic [1:0]  r_pos;
    logic        r_valid;
    logic [15:0] r_unit;
    logic        r_run_end;
    logic        r_text_end;

    logic        load;
    logic [2:0]  total;
    logic        at_end;
    logic [15:0] unit;

    assign load   = (!r_valid || !i_out_stall) && i_job_valid;
    assign total  = {1'b0, i_job.rep_cnt} + {1'b0, i_job.tail_n};
    assign at_end = ({1'b0, r_pos} == total - 3'd1);
    assign o_pop  = load && at_end;

    always_comb begin
        if (r_pos < i_job.rep_cnt) begin
            unit = u8u16_pkg::REPL_UNIT;
        end else if (r_pos == i_job.rep_cnt) begin
            unit = i_job.tail_hi;
        end else begin
            unit = i_job.tail_lo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_unit     <= unit;
            r_run_end  <= at_end;
            r_text_end <= at_end && i_job.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= 2'd0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= at_end ? 2'd0 : r_pos + 2'd1;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_valid;
    assign o_code_unit = r_unit;
    assign o_run_end   = r_run_end;
    assign o_text_end  = r_text_end;

endmodule

// ===== dv/utf8_to_utf16_transcoder_tb.sv =====
// self-checking testbench for the utf-8 to utf-16 transcoder
// depends on u8u16_pkg and utf8_to_utf16_transcoder; directed table, then random texts
// every word leaving the block is checked against the table or a behavioral decoder
`timescale 1ns / 100ps

module utf8_to_utf16_transcoder_tb;

    localparam int DIR_N       = 25;    // rows in the directed table
    localparam int PHASE_BYTES = 70;    // random bytes per idling phase
    localparam int QUIET_LIMIT = 2000;  // cycles without any word moving
    localparam int HOLD_CYCLES = 60;    // long receiver hold-off
    localparam int TAIL_CYCLES = 20;    // settle time after the last word

    // one directed row: byte, last flag, and an optional typed-in answer
    // (n_units copies of unit; the decoder is used when typed is clear)
    typedef struct packed {
        logic [7:0]  byte_val;
        logic        last;
        logic        typed;
        logic [2:0]  n_units;
        logic [15:0] unit;
    } t_row;

    // one expected word on the output side
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_end;
        logic        text_end;
    } t_utf16_word;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic [7:0]  i_byte_in   = 8'h00;
    logic        i_last_byte = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [15:0] o_code_unit;
    logic        o_run_end;
    logic        o_text_end;

    // decoder state: payload bits so far, bytes held, full sequence length
    logic [20:0] cp_bits = '0;
    logic [2:0]  held_n  = '0;
    logic [2:0]  seq_len = '0;

    // words caused by the byte being decoded right now
    logic [15:0] step_unit [4];
    int          step_n;

    t_utf16_word due_words [$];
    t_utf16_word got_word;
    logic [7:0]  text_bytes [$];

    int fail_cnt    = 0;
    int bytes_sent  = 0;
    int quiet_cnt   = 0;
    int snd_idle    = 0;    // percent of slots the sender leaves empty
    int rcv_idle    = 0;    // percent of cycles the receiver stalls
    bit hold_go     = 1'b0;
    bit hold_used   = 1'b0;

    // directed stimulus: extremes, error codes, every sequence length
    t_row dir_rows [DIR_N] = '{
        {8'h00, 1'b0, 1'b1, 3'd1, 16'h0000},  // lowest ascii
        {8'h7F, 1'b0, 1'b1, 3'd1, 16'h007F},  // highest ascii
        {8'h80, 1'b0, 1'b1, 3'd1, u8u16_pkg::REPL_UNIT}, // lone continuation
        {8'hFF, 1'b0, 1'b1, 3'd1, u8u16_pkg::REPL_UNIT}, // invalid lead
        {8'hC0, 1'b0, 1'b1, 3'd0, 16'h0000},  // two-byte lead, nothing yet
        {8'h80, 1'b0, 1'b1, 3'd1, u8u16_pkg::REPL_UNIT}, // overlong nul
        {8'hE0, 1'b0, 1'b0, 3'd0, 16'h0000},  // smallest three-byte point
        {8'hA0, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'h80, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'hED, 1'b0, 1'b0, 3'd0, 16'h0000},  // encoded surrogate
        {8'hA0, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'h80, 1'b0, 1'b1, 3'd1, u8u16_pkg::REPL_UNIT},
        {8'hF4, 1'b0, 1'b0, 3'd0, 16'h0000},  // highest point, surrogate pair
        {8'h8F, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'hBF, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'hBF, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'hF4, 1'b0, 1'b0, 3'd0, 16'h0000},  // just past the highest point
        {8'h90, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'h80, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'h80, 1'b0, 1'b1, 3'd1, u8u16_pkg::REPL_UNIT},
        {8'hE2, 1'b0, 1'b0, 3'd0, 16'h0000},  // sequence broken by ascii
        {8'h41, 1'b0, 1'b0, 3'd0, 16'h0000},
        {8'hE2, 1'b0, 1'b0, 3'd0, 16'h0000},  // text ends mid-sequence
        {8'h82, 1'b1, 1'b1, 3'd2, u8u16_pkg::REPL_UNIT},
        {8'hF0, 1'b1, 1'b1, 3'd1, u8u16_pkg::REPL_UNIT}  // text ends on a lead byte
    };

    utf8_to_utf16_transcoder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_byte_in   (i_byte_in),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_code_unit (o_code_unit),
        .o_run_end   (o_run_end),
        .o_text_end  (o_text_end)
    );

    always #10 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // behavioral decoder
    // ---------------------------------------------------------------

    function automatic void add_unit(input logic [15:0] u);
        if (step_n < 4) begin
            step_unit[step_n] = u;
            step_n++;
        end
    endfunction

    function automatic void clear_seq();
        cp_bits = '0;
        held_n  = '0;
        seq_len = '0;
    endfunction

    // every byte still held turns into one replacement word
    function automatic void flush_held();
        for (int k = 0; k < held_n; k++) begin
            add_unit(u8u16_pkg::REPL_UNIT);
        end
        clear_seq();
    endfunction

    // a byte seen with nothing pending
    function automatic void start_lead(input logic [7:0] b, input logic last);
        if (!b[7]) begin
            add_unit({8'h00, b});
        end else if (b[7:5] == 3'b110 || b[7:4] == 4'b1110 || b[7:3] == 5'b11110) begin
            if (last) begin
                add_unit(u8u16_pkg::REPL_UNIT);
            end else begin
                held_n = 3'd1;
                if (b[7:5] == 3'b110) begin
                    seq_len = u8u16_pkg::LEN_TWO;
                    cp_bits = {16'd0, b[4:0]};
                end else if (b[7:4] == 4'b1110) begin
                    seq_len = u8u16_pkg::LEN_THREE;
                    cp_bits = {17'd0, b[3:0]};
                end else begin
                    seq_len = u8u16_pkg::LEN_FOUR;
                    cp_bits = {18'd0, b[2:0]};
                end
            end
        end else begin
            // stray continuation or lead 0xf8 and up
            add_unit(u8u16_pkg::REPL_UNIT);
        end
    endfunction

    // decode one accepted byte; leaves its words in step_unit
    function automatic void predict_byte(input logic [7:0] b, input logic last);
        logic        bad;
        logic [20:0] v;
        step_n = 0;
        if (held_n != 0) begin
            if (b[7:6] == 2'b10) begin
                cp_bits = {cp_bits[14:0], b[5:0]};
                held_n  = held_n + 3'd1;
                if (held_n >= seq_len) begin
                    // overlong, surrogate and out-of-range points collapse to one word
                    if (seq_len == u8u16_pkg::LEN_TWO)
                        bad = cp_bits < u8u16_pkg::MIN_LEN2;
                    else if (seq_len == u8u16_pkg::LEN_THREE)
                        bad = cp_bits < u8u16_pkg::MIN_LEN3
                              || (cp_bits >= u8u16_pkg::SURR_FIRST
                                  && cp_bits <= u8u16_pkg::SURR_LAST);
                    else
                        bad = cp_bits < u8u16_pkg::MIN_LEN4
                              || cp_bits > u8u16_pkg::MAX_POINT;
                    if (bad) begin
                        add_unit(u8u16_pkg::REPL_UNIT);
                    end else if (cp_bits <= u8u16_pkg::BMP_LAST) begin
                        add_unit(cp_bits[15:0]);
                    end else begin
                        v = cp_bits - u8u16_pkg::MIN_LEN4;
                        add_unit(u8u16_pkg::HI_SURR_BASE + {6'd0, v[19:10]});
                        add_unit(u8u16_pkg::LO_SURR_BASE
                                 + {6'd0, v[9:0] & u8u16_pkg::SURR_MASK});
                    end
                    clear_seq();
                end else if (last) begin
                    flush_held();
                end
            end else begin
                // broken sequence: flush, then decode the breaking byte afresh
                flush_held();
                start_lead(b, last);
            end
        end else begin
            start_lead(b, last);
        end
        if (last)
            clear_seq();
    endfunction

    // ---------------------------------------------------------------
    // sender
    // ---------------------------------------------------------------

    // offer one byte, wait for the handshake, then queue the words it causes
    task automatic send_byte(input logic [7:0] b, input logic last, input t_row row);
        t_utf16_word w;
        int          n;
        while ($urandom_range(99) < snd_idle) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_in_valid  <= 1'b1;
        i_byte_in   <= b;
        i_last_byte <= last;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        bytes_sent++;
        predict_byte(b, last);
        // typed rows use the table's answer; the decoder still tracks state
        n = row.typed ? int'(row.n_units) : step_n;
        for (int k = 0; k < n; k++) begin
            w.code_unit = row.typed ? row.unit : step_unit[k];
            w.run_end   = (k == n - 1);
            w.text_end  = (k == n - 1) && last;
            due_words.push_back(w);
        end
    endtask

    // drop valid and wait until every expected word has come back
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_words.size() != 0)
            @(posedge i_clk);
    endtask

    // build one random text: mostly well-formed characters, some cut short,
    // some overlong or out of range, some raw noise bytes; then send it
    task automatic send_text();
        int          n_chars;
        int          kind;
        int          len;
        int          keep;
        logic [20:0] cp;
        logic [7:0]  seq [4];
        t_row        no_row;
        no_row = '0;
        text_bytes.delete();
        n_chars = $urandom_range(1, 10);
        for (int c = 0; c < n_chars; c++) begin
            kind = $urandom_range(99);
            if (kind >= 85) begin
                text_bytes.push_back(8'($urandom_range(255)));
            end else begin
                len = $urandom_range(1, 4);
                // a small share spans the whole payload range of the length
                case (len)
                    1: cp = 21'($urandom_range(8'h7F));
                    2: cp = (kind < 8) ? 21'($urandom_range(11'h7FF))
                                       : 21'($urandom_range(8'h80, 11'h7FF));
                    3: cp = (kind < 8) ? 21'($urandom_range(16'hFFFF))
                                       : 21'($urandom_range(12'h800, 16'hFFFF));
                    default: cp = (kind < 8) ? 21'($urandom_range(21'h1FFFFF))
                                             : 21'($urandom_range(17'h10000, 21'h10FFFF));
                endcase
                case (len)
                    1: seq[0] = cp[7:0];
                    2: begin
                        seq[0] = {3'b110, cp[10:6]};
                        seq[1] = {2'b10, cp[5:0]};
                    end
                    3: begin
                        seq[0] = {4'b1110, cp[15:12]};
                        seq[1] = {2'b10, cp[11:6]};
                        seq[2] = {2'b10, cp[5:0]};
                    end
                    default: begin
                        seq[0] = {5'b11110, cp[20:18]};
                        seq[1] = {2'b10, cp[17:12]};
                        seq[2] = {2'b10, cp[11:6]};
                        seq[3] = {2'b10, cp[5:0]};
                    end
                endcase
                keep = len;
                if (kind >= 70 && len > 1)
                    keep = $urandom_range(1, len - 1);
                for (int j = 0; j < keep; j++)
                    text_bytes.push_back(seq[j]);
            end
        end
        for (int j = 0; j < text_bytes.size(); j++)
            send_byte(text_bytes[j], j == text_bytes.size() - 1, no_row);
    endtask

    // one idling phase of random texts, ended by a full drain
    task automatic run_phase(input int snd_pct, input int rcv_pct, input bit hold);
        int start_cnt;
        snd_idle  = snd_pct;
        rcv_idle  = rcv_pct;
        hold_go   = hold;
        start_cnt = bytes_sent;
        while (bytes_sent - start_cnt < PHASE_BYTES)
            send_text();
        wait_drained();
    endtask

    // ---------------------------------------------------------------
    // receiver: random stalls, plus one long hold-off on request
    // ---------------------------------------------------------------

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_go && !hold_used) begin
                // hold long enough for the job queue to fill and stall the input
                hold_used = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1)
                    @(negedge i_clk);
            end else begin
                i_out_stall <= ($urandom_range(99) < rcv_idle);
            end
        end
    end

    // ---------------------------------------------------------------
    // output check and watchdog
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (due_words.size() == 0) begin
                $error("code_unit %h arrived with nothing expected", o_code_unit);
                fail_cnt++;
            end else begin
                got_word = due_words.pop_front();
                if (o_code_unit !== got_word.code_unit) begin
                    $error("code_unit expected %h actual %h", got_word.code_unit, o_code_unit);
                    fail_cnt++;
                end
                if (o_run_end !== got_word.run_end) begin
                    $error("run_end expected %b actual %b", got_word.run_end, o_run_end);
                    fail_cnt++;
                end
                if (o_text_end !== got_word.text_end) begin
                    $error("text_end expected %b actual %b", got_word.text_end, o_text_end);
                    fail_cnt++;
                end
            end
        end
    end

    // any word moving on either side resets the count
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cnt <= 0;
        else
            quiet_cnt <= quiet_cnt + 1;
        if (quiet_cnt >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // main sequence
    // ---------------------------------------------------------------

    initial begin
        repeat (6)
            @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed table under the first idling mix
        snd_idle = 21;
        rcv_idle = 58;
        for (int r = 0; r < DIR_N; r++)
            send_byte(dir_rows[r].byte_val, dir_rows[r].last, dir_rows[r]);

        // sender idles rarely, receiver often, then the reverse, then none;
        // the last phase opens with the long receiver hold-off
        run_phase(21, 58, 1'b0);
        run_phase(58, 21, 1'b0);
        run_phase(0, 0, 1'b1);

        // catch any stray word after the last expected one
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
        if (fail_cnt == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== utf8_to_utf16_transcoder.f =====
design/u8u16_pkg.sv
design/u8u16_front.sv
design/u8u16_queue.sv
design/u8u16_back.sv
design/utf8_to_utf16_transcoder.sv
dv/utf8_to_utf16_transcoder_tb.sv
